// File: src/two_level_page_walk_assert.svh
// ============================================================================
// two_level_page_walk_assert.svh
// Assertion macros used by the page walker RTL (tlpw_ctrl). They sample on clk and
// are disabled while rst_n is low.
// ============================================================================
`ifndef TWO_LEVEL_PAGE_WALK_ASSERT_SVH
`define TWO_LEVEL_PAGE_WALK_ASSERT_SVH

// same-cycle implication
`define TLPW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page walk assertion failed");

// next-cycle implication
`define TLPW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page walk assertion failed");

`endif

// File: src/tlpw_pkg.sv
// ============================================================================
// tlpw_pkg
// Types and constants of the two-level page walker.
// ============================================================================
package tlpw_pkg;

    localparam int MAX_PAGES_DEF  = 64;
    localparam int PAGE_BYTES     = 4096;
    localparam int WORDS_PER_PAGE = PAGE_BYTES / 4;
    localparam int OFS_W          = $clog2(WORDS_PER_PAGE);
    localparam int PAGE_SHIFT     = 12;
    localparam int L1_SHIFT       = 22;
    localparam int PN_W           = 32 - PAGE_SHIFT;
    localparam int PCNT_W         = 7;

    localparam logic [PCNT_W-1:0] PAGE_COUNT_RESET = 7'd64;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_XLATE = 2'd2;

    localparam logic [1:0] ACC_READ  = 2'd0;
    localparam logic [1:0] ACC_WRITE = 2'd1;
    localparam logic [1:0] ACC_EXEC  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_ADDR = 2'd1;
    localparam logic [1:0] ST_BAD_PERM = 2'd2;
    localparam logic [1:0] ST_BAD_IO   = 2'd3;

    localparam int PTE_VALID    = 0;
    localparam int PTE_PRESENT  = 1;
    localparam int PTE_READ     = 2;
    localparam int PTE_WRITE    = 3;
    localparam int PTE_EXEC     = 4;
    localparam int PTE_USER     = 5;
    localparam int PTE_ACCESSED = 6;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] word_address;
        logic [31:0] write_data;
        logic [31:0] table_root;
        logic [31:0] virtual_address;
        logic [1:0]  access_kind;
        logic        user_mode;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] physical_address;
        logic [31:0] read_data;
    } rsp_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

endpackage

// File: src/tlpw_mem.sv
// ============================================================================
// tlpw_mem
// Single-port physical word memory, one access per cycle, registered read.
// ============================================================================
module tlpw_mem #(
    parameter int MEM_WORDS = tlpw_pkg::MAX_PAGES_DEF * tlpw_pkg::WORDS_PER_PAGE,
    parameter int MEM_AW    = $clog2(tlpw_pkg::MAX_PAGES_DEF) + tlpw_pkg::OFS_W
) (
    input  logic                clk,
    input  tlpw_pkg::mem_cmd_t  cmd,
    input  logic [MEM_AW-1:0]   addr,
    input  logic [31:0]         wdata,
    output logic [31:0]         rdata
);

    logic [31:0] mem_array [MEM_WORDS];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem_array[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem_array[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/tlpw_ctrl.sv
// ============================================================================
// tlpw_ctrl
// Command sequencer: memory read/write, level-one and level-two entry
// checks with accessed-bit write-back, page_count register, result word.
// ============================================================================
`include "two_level_page_walk_assert.svh"

module tlpw_ctrl #(
    parameter int MAX_PAGES = tlpw_pkg::MAX_PAGES_DEF,
    parameter int MEM_AW    = $clog2(tlpw_pkg::MAX_PAGES_DEF) + tlpw_pkg::OFS_W
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  tlpw_pkg::req_t                    request,
    output logic                              done,
    output tlpw_pkg::rsp_t                    result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tlpw_pkg::PCNT_W-1:0]       cfg_data,
    output tlpw_pkg::mem_cmd_t                mem_cmd,
    output logic [MEM_AW-1:0]                 mem_addr,
    output logic [31:0]                       mem_wdata,
    input  logic [31:0]                       mem_rdata
);

    localparam int PG_W = MEM_AW - tlpw_pkg::OFS_W;
    localparam int PN_W = tlpw_pkg::PN_W;
    localparam logic [31:0]   MEM_WORDS_L = 32'(MAX_PAGES * tlpw_pkg::WORDS_PER_PAGE);
    localparam logic [PN_W:0] MAX_LIM     = (PN_W+1)'(MAX_PAGES);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXEC    = 6'b000010,
        S_RD_WAIT = 6'b000100,
        S_L1_CHK  = 6'b001000,
        S_L2_RD   = 6'b010000,
        S_L2_CHK  = 6'b100000
    } state_t;

    state_t                      state_reg, state_next;
    tlpw_pkg::req_t              req_reg, req_next;
    logic [PN_W-1:0]             frame_reg, frame_next;
    logic [tlpw_pkg::PCNT_W-1:0] page_count_reg;
    logic                        done_reg, done_next;
    tlpw_pkg::rsp_t              rsp_reg, rsp_next;

    logic [PN_W-1:0] root_page;
    logic [PN_W-1:0] e1_page;
    logic [9:0]      l1_idx;
    logic [9:0]      l2_idx;
    logic [31:0]     wa_ext;
    logic            wa_ok;
    logic            root_ok;
    logic            e1_ok;
    logic            perm_ok;

    function automatic logic page_in_range(logic [PN_W-1:0] pg,
                                           logic [tlpw_pkg::PCNT_W-1:0] cnt);
        page_in_range = ({1'b0, pg} < MAX_LIM) && (pg < PN_W'(cnt));
    endfunction

    assign root_page = req_reg.table_root[31:tlpw_pkg::PAGE_SHIFT];
    assign e1_page   = mem_rdata[31:tlpw_pkg::PAGE_SHIFT];
    assign l1_idx    = req_reg.virtual_address[31:tlpw_pkg::L1_SHIFT];
    assign l2_idx    = req_reg.virtual_address[tlpw_pkg::L1_SHIFT-1:tlpw_pkg::PAGE_SHIFT];
    assign wa_ext    = 32'(req_reg.word_address);
    assign wa_ok     = wa_ext < MEM_WORDS_L;
    assign root_ok   = (req_reg.table_root[tlpw_pkg::PAGE_SHIFT-1:0] == '0)
                       && page_in_range(root_page, page_count_reg);
    assign e1_ok     = page_in_range(e1_page, page_count_reg);

    always_comb
    begin
        case (req_reg.access_kind)
            tlpw_pkg::ACC_READ:  perm_ok = mem_rdata[tlpw_pkg::PTE_READ];
            tlpw_pkg::ACC_WRITE: perm_ok = mem_rdata[tlpw_pkg::PTE_WRITE];
            tlpw_pkg::ACC_EXEC:  perm_ok = mem_rdata[tlpw_pkg::PTE_EXEC];
            default:             perm_ok = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        frame_next = frame_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        mem_cmd    = '0;
        mem_addr   = {root_page[PG_W-1:0], l1_idx};
        mem_wdata  = req_reg.write_data;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                rsp_next   = '0;
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (req_reg.operation)
                    tlpw_pkg::OP_WRITE:
                    begin
                        mem_addr = wa_ext[MEM_AW-1:0];
                        if (wa_ok)
                        begin
                            mem_cmd.wr = 1'b1;
                        end
                        else
                        begin
                            rsp_next.status = tlpw_pkg::ST_BAD_ADDR;
                        end
                    end
                    tlpw_pkg::OP_READ:
                    begin
                        mem_addr = wa_ext[MEM_AW-1:0];
                        if (wa_ok)
                        begin
                            mem_cmd.rd = 1'b1;
                            state_next = S_RD_WAIT;
                            done_next  = 1'b0;
                        end
                        else
                        begin
                            rsp_next.status = tlpw_pkg::ST_BAD_ADDR;
                        end
                    end
                    tlpw_pkg::OP_XLATE:
                    begin
                        if (req_reg.table_root[tlpw_pkg::PAGE_SHIFT-1:0] != '0)
                        begin
                            rsp_next.status = tlpw_pkg::ST_BAD_IO;
                        end
                        else if (!root_ok)
                        begin
                            rsp_next.status = tlpw_pkg::ST_BAD_ADDR;
                        end
                        else
                        begin
                            mem_cmd.rd = 1'b1;
                            state_next = S_L1_CHK;
                            done_next  = 1'b0;
                        end
                    end
                    default:
                    begin
                        rsp_next.status = tlpw_pkg::ST_BAD_IO;
                    end
                endcase
            end
            S_RD_WAIT:
            begin
                rsp_next.read_data = mem_rdata;
                done_next          = 1'b1;
                state_next         = S_IDLE;
            end
            S_L1_CHK:
            begin
                frame_next = e1_page;
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (!mem_rdata[tlpw_pkg::PTE_VALID])
                begin
                    rsp_next.status = tlpw_pkg::ST_BAD_ADDR;
                end
                else if (!mem_rdata[tlpw_pkg::PTE_PRESENT])
                begin
                    rsp_next.status = tlpw_pkg::ST_BAD_IO;
                end
                else
                begin
                    mem_cmd.wr = 1'b1;
                    mem_wdata  = mem_rdata | (32'd1 << tlpw_pkg::PTE_ACCESSED);
                    if (!e1_ok)
                    begin
                        rsp_next.status = tlpw_pkg::ST_BAD_ADDR;
                    end
                    else
                    begin
                        state_next = S_L2_RD;
                        done_next  = 1'b0;
                    end
                end
            end
            S_L2_RD:
            begin
                mem_addr   = {frame_reg[PG_W-1:0], l2_idx};
                mem_cmd.rd = 1'b1;
                state_next = S_L2_CHK;
            end
            S_L2_CHK:
            begin
                mem_addr   = {frame_reg[PG_W-1:0], l2_idx};
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (!mem_rdata[tlpw_pkg::PTE_VALID])
                begin
                    rsp_next.status = tlpw_pkg::ST_BAD_ADDR;
                end
                else if (req_reg.user_mode && !mem_rdata[tlpw_pkg::PTE_USER])
                begin
                    rsp_next.status = tlpw_pkg::ST_BAD_PERM;
                end
                else if (!perm_ok)
                begin
                    rsp_next.status = tlpw_pkg::ST_BAD_PERM;
                end
                else if (!mem_rdata[tlpw_pkg::PTE_PRESENT])
                begin
                    rsp_next.status = tlpw_pkg::ST_BAD_IO;
                end
                else
                begin
                    mem_cmd.wr = 1'b1;
                    mem_wdata  = mem_rdata | (32'd1 << tlpw_pkg::PTE_ACCESSED);
                    rsp_next.physical_address =
                        {mem_rdata[31:tlpw_pkg::PAGE_SHIFT],
                         req_reg.virtual_address[tlpw_pkg::PAGE_SHIFT-1:0]};
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            page_count_reg <= tlpw_pkg::PAGE_COUNT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                page_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        frame_reg <= frame_next;
        rsp_reg   <= rsp_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign done      = done_reg;
    assign result    = rsp_reg;

    `TLPW_ASSERT_NEXT(a_accept_exec, start && !busy, state_reg == S_EXEC)
    `TLPW_ASSERT_NEXT(a_l2_done, state_reg == S_L2_CHK, done_reg)
    `TLPW_ASSERT_NOW(a_one_access, mem_cmd.rd, !mem_cmd.wr)
    `TLPW_ASSERT_NOW(a_err_no_pa, done_reg && (rsp_reg.status != tlpw_pkg::ST_OK),
                     rsp_reg.physical_address == 32'd0)

endmodule

// File: src/two_level_page_walk.sv
// ============================================================================
// two_level_page_walk
// Two-level page table walker over a local single-port word memory.
// ============================================================================
// A command is taken when start is high and busy is low; its result word
// appears on result with done high for exactly one cycle and cannot be
// held off. A write or a command rejected before any table read sets done
// from S_EXEC, a read from S_RD_WAIT, a walk that stops at the level-one
// entry from S_L1_CHK, and a walk that reaches the level-two entry from
// S_L2_CHK after S_L1_CHK and S_L2_RD (level-one read, accessed-bit write,
// level-two read, accessed-bit write, all through the one memory port).
// busy drops in the cycle done rises, so the next command can be taken
// then. The memory holds no reset contents; page_count may be written
// while busy is low through cfg_valid/cfg_ready.
module two_level_page_walk #(
    parameter int MAX_PAGES = tlpw_pkg::MAX_PAGES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  tlpw_pkg::req_t              request,
    output logic                        done,
    output tlpw_pkg::rsp_t              result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tlpw_pkg::PCNT_W-1:0] cfg_data
);

    localparam int MEM_WORDS = MAX_PAGES * tlpw_pkg::WORDS_PER_PAGE;
    localparam int MEM_AW    = $clog2(MAX_PAGES) + tlpw_pkg::OFS_W;

    tlpw_pkg::mem_cmd_t mem_cmd;
    logic [MEM_AW-1:0]  mem_addr;
    logic [31:0]        mem_wdata;
    logic [31:0]        mem_rdata;

    tlpw_ctrl #(
        .MAX_PAGES (MAX_PAGES),
        .MEM_AW    (MEM_AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .mem_cmd   (mem_cmd),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    tlpw_mem #(
        .MEM_WORDS (MEM_WORDS),
        .MEM_AW    (MEM_AW)
    ) u_mem (
        .clk   (clk),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule
